// ===== rtl/unique_value_slot_table_defines.svh =====
// Assertion macros shared by the checker of the slot table.
// Depends on nothing; included by the files that assert.
`ifndef UNIQUE_VALUE_SLOT_TABLE_DEFINES_SVH
`define UNIQUE_VALUE_SLOT_TABLE_DEFINES_SVH

// Implication in the same cycle, checked out of reset.
`define UVST_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("slot table check failed in the same cycle");

// Implication into the following cycle, checked out of reset.
`define UVST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("slot table check failed in the following cycle");

`endif

// ===== rtl/uvst_pkg.sv =====
// Package for the unique value slot table: opcodes, status codes and field widths.
// Depends on nothing; used by the top level and its checker.
package uvst_pkg;

    localparam int unsigned OP_W    = 3;
    localparam int unsigned VAL_W   = 32;
    localparam int unsigned SLOT_W  = 3;
    localparam int unsigned ST_W    = 3;
    localparam int unsigned IN_TDATA_W  = 72;
    localparam int unsigned OUT_TDATA_W = 40;

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_RMVAL  = 3'd1;
    localparam logic [OP_W-1:0] OP_RMPOS  = 3'd2;
    localparam logic [OP_W-1:0] OP_REPL   = 3'd3;
    localparam logic [OP_W-1:0] OP_LOOKUP = 3'd4;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
    localparam logic [ST_W-1:0] ST_DUP      = 3'd2;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [ST_W-1:0] ST_BADPOS   = 3'd4;

endpackage

// ===== rtl/unique_value_slot_table.sv =====
// Unique value slot table: a table of signed 32-bit slots, zero meaning empty.
// A scanning request reads every slot in S_SCAN, then evaluates and loads its item in S_EVAL; remove
// by position goes straight to S_EVAL; a dump loads one slot per pass through S_DRD and S_DWT.
// A new request is accepted only in S_IDLE, once the last one is done; the single memory read port
// scans one slot per cycle; a held output item stalls the table until it is taken.
// Reset is synchronous: control state and the per-slot valid bits clear, so slots read empty.
module unique_value_slot_table #(
    parameter int DEPTH = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // key [31:0], new_value [63:32], slot_index [66:64], zero fill
    input  logic [uvst_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    // opcode [2:0]
    input  logic [uvst_pkg::OP_W-1:0]         i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // slot_found [2:0], slot_value [34:3], zero fill
    output logic [uvst_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    // status [2:0]
    output logic [uvst_pkg::ST_W-1:0]         o_m_tuser,
    output logic                              o_m_tlast
);
    import uvst_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_EVAL = 5'b00100,
        S_DRD  = 5'b01000,
        S_DWT  = 5'b10000
    } t_state;

    t_state                   r_state;
    logic [OP_W-1:0]          r_op;
    logic signed [VAL_W-1:0]  r_key;
    logic signed [VAL_W-1:0]  r_nv;
    logic [SLOT_W-1:0]        r_idx;
    logic [AW-1:0]            r_addr;
    logic                     r_scan_done;
    logic                     r_rd_vld;
    logic                     r_rd_last;
    logic [AW-1:0]            r_rd_idx;
    logic [VAL_W-1:0]         r_rd_data;
    logic                     r_rd_vbit;
    logic                     r_hit;
    logic [AW-1:0]            r_hit_idx;
    logic                     r_emp;
    logic [AW-1:0]            r_emp_idx;
    logic [DEPTH-1:0]         r_vld;
    logic [VAL_W-1:0]         r_mem [DEPTH];

    logic                     r_o_vld;
    logic [ST_W-1:0]          r_o_st;
    logic [SLOT_W-1:0]        r_o_slot;
    logic [VAL_W-1:0]         r_o_val;
    logic                     r_o_last;

    logic                     n_accept;
    logic                     n_out_free;
    logic                     n_rd_en;
    logic [AW-1:0]            n_rd_addr;
    logic [VAL_W-1:0]         n_rd_val;
    logic [ST_W-1:0]          n_status;
    logic                     n_wr;
    logic [AW-1:0]            n_wr_addr;
    logic [VAL_W-1:0]         n_wr_data;
    logic [AW-1:0]            n_slot;
    logic [VAL_W-1:0]         n_val;
    logic                     n_wr_en;
    logic                     n_load;
    logic [ST_W-1:0]          n_o_st;
    logic [AW-1:0]            n_o_slot;
    logic [VAL_W-1:0]         n_o_val;
    logic                     n_o_last;
    logic [AW+SLOT_W-1:0]     n_slot_ext;

    assign o_s_tready = (r_state == S_IDLE);
    assign n_accept   = i_s_tvalid && o_s_tready;
    assign n_out_free = !r_o_vld || i_m_tready;
    assign n_rd_val   = r_rd_vbit ? r_rd_data : '0;

    assign n_rd_en   = ((r_state == S_SCAN) && !r_scan_done) || (r_state == S_DRD);
    assign n_rd_addr = r_addr;

    always_comb begin
        n_status  = ST_OK;
        n_wr      = 1'b0;
        n_wr_addr = '0;
        n_wr_data = '0;
        n_slot    = '0;
        n_val     = '0;
        case (r_op)
            OP_INSERT: begin
                if (r_hit) begin
                    n_status = ST_DUP;
                end else if (r_emp) begin
                    n_wr      = 1'b1;
                    n_wr_addr = r_emp_idx;
                    n_wr_data = r_key;
                    n_slot    = r_emp_idx;
                    n_val     = r_key;
                end else begin
                    n_status = ST_FULL;
                end
            end
            OP_RMVAL: begin
                if (r_hit) begin
                    n_wr      = 1'b1;
                    n_wr_addr = r_hit_idx;
                    n_slot    = r_hit_idx;
                end else begin
                    n_status = ST_NOTFOUND;
                end
            end
            OP_RMPOS: begin
                if (32'(r_idx) < DEPTH) begin
                    n_wr      = 1'b1;
                    n_wr_addr = AW'(r_idx);
                    n_slot    = AW'(r_idx);
                end else begin
                    n_status = ST_BADPOS;
                end
            end
            OP_REPL: begin
                if (r_hit) begin
                    n_wr      = 1'b1;
                    n_wr_addr = r_hit_idx;
                    n_wr_data = r_nv;
                    n_slot    = r_hit_idx;
                    n_val     = r_nv;
                end else begin
                    n_status = ST_NOTFOUND;
                end
            end
            OP_LOOKUP: begin
                if (r_hit) begin
                    n_slot = r_hit_idx;
                    n_val  = r_key;
                end else begin
                    n_status = ST_NOTFOUND;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    assign n_wr_en = (r_state == S_EVAL) && n_out_free && n_wr;

    always_comb begin
        n_load   = 1'b0;
        n_o_st   = ST_OK;
        n_o_slot = '0;
        n_o_val  = '0;
        n_o_last = 1'b1;
        if ((r_state == S_EVAL) && n_out_free) begin
            n_load   = 1'b1;
            n_o_st   = n_status;
            n_o_slot = n_slot;
            n_o_val  = n_val;
        end else if ((r_state == S_DWT) && n_out_free) begin
            n_load   = 1'b1;
            n_o_slot = r_addr;
            n_o_val  = n_rd_val;
            n_o_last = (r_addr == LAST_ADDR);
        end
    end

    assign n_slot_ext = {{SLOT_W{1'b0}}, n_o_slot};

    // Slot memory with one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (n_wr_en) begin
            r_mem[n_wr_addr] <= n_wr_data;
        end
        if (n_rd_en) begin
            r_rd_data <= r_mem[n_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_rd_vbit <= 1'b0;
        end else begin
            if (n_wr_en) begin
                r_vld[n_wr_addr] <= 1'b1;
            end
            if (n_rd_en) begin
                r_rd_vbit <= r_vld[n_rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_op  <= i_s_tuser;
            r_key <= i_s_tdata[31:0];
            r_nv  <= i_s_tdata[63:32];
            r_idx <= i_s_tdata[66:64];
        end
        if (r_rd_vld) begin
            if (!r_hit && (n_rd_val == r_key)) begin
                r_hit_idx <= r_rd_idx;
            end
            if (!r_emp && (n_rd_val == '0)) begin
                r_emp_idx <= r_rd_idx;
            end
        end
        r_rd_idx <= r_addr;
        if (n_load) begin
            r_o_st   <= n_o_st;
            r_o_slot <= n_slot_ext[SLOT_W-1:0];
            r_o_val  <= n_o_val;
            r_o_last <= n_o_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_addr      <= '0;
            r_scan_done <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_rd_last   <= 1'b0;
            r_hit       <= 1'b0;
            r_emp       <= 1'b0;
            r_o_vld     <= 1'b0;
        end else begin
            r_rd_vld  <= (r_state == S_SCAN) && !r_scan_done;
            r_rd_last <= (r_state == S_SCAN) && !r_scan_done && (r_addr == LAST_ADDR);
            if (r_rd_vld) begin
                if (n_rd_val == r_key) begin
                    r_hit <= 1'b1;
                end
                if (n_rd_val == '0) begin
                    r_emp <= 1'b1;
                end
            end
            if (n_load) begin
                r_o_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_o_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_addr      <= '0;
                    r_scan_done <= 1'b0;
                    r_hit       <= 1'b0;
                    r_emp       <= 1'b0;
                    if (n_accept) begin
                        case (i_s_tuser)
                            OP_INSERT, OP_RMVAL, OP_REPL: begin
                                r_state <= S_SCAN;
                            end
                            OP_RMPOS: begin
                                r_state <= S_EVAL;
                            end
                            OP_LOOKUP: begin
                                if (i_s_tdata[31:0] == '0) begin
                                    r_state <= S_DRD;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (!r_scan_done) begin
                        if (r_addr == LAST_ADDR) begin
                            r_scan_done <= 1'b1;
                        end else begin
                            r_addr <= r_addr + 1'b1;
                        end
                    end
                    if (r_rd_vld && r_rd_last) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (n_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                S_DRD: begin
                    r_state <= S_DWT;
                end
                S_DWT: begin
                    if (n_out_free) begin
                        if (r_addr == LAST_ADDR) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_addr  <= r_addr + 1'b1;
                            r_state <= S_DRD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_o_vld;
    assign o_m_tuser  = r_o_st;
    assign o_m_tlast  = r_o_last;
    assign o_m_tdata  = {{(OUT_TDATA_W - SLOT_W - VAL_W){1'b0}}, r_o_val, r_o_slot};

endmodule

// ===== rtl/uvst_checker.sv =====
// Port checker for the unique value slot table, bound to the top level.
// Depends on uvst_pkg and unique_value_slot_table_defines.svh.
`include "unique_value_slot_table_defines.svh"

module uvst_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_tvalid,
    input logic                              o_s_tready,
    input logic [uvst_pkg::OP_W-1:0]         i_s_tuser,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [uvst_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    input logic [uvst_pkg::ST_W-1:0]         o_m_tuser,
    input logic                              o_m_tlast
);
    import uvst_pkg::*;

    `UVST_ASSERT_SAME(a_fail_is_empty, i_clk, i_rst_n,
        o_m_tvalid && (o_m_tuser != ST_OK), (o_m_tdata == '0) && o_m_tlast)
    `UVST_ASSERT_SAME(a_dump_is_ok, i_clk, i_rst_n,
        o_m_tvalid && !o_m_tlast, o_m_tuser == ST_OK)
    `UVST_ASSERT_SAME(a_status_legal, i_clk, i_rst_n,
        o_m_tvalid, o_m_tuser <= ST_BADPOS)
    `UVST_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n,
        i_s_tvalid && o_s_tready && (i_s_tuser <= OP_LOOKUP), !o_s_tready)
    `UVST_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready,
        o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast))

endmodule

bind unique_value_slot_table uvst_checker u_uvst_checker (.*);

// ===== tb/sv/tb_unique_value_slot_table.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the unique value slot table: directed rows, then random requests.
// Needs only uvst_pkg and the unique_value_slot_table top level.
module tb_unique_value_slot_table;
    import uvst_pkg::*;

    localparam int TABLE_DEPTH  = 4;
    localparam int HOLD_CYCLES  = 200;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 24;
    localparam int PHASE_ITEMS  = 112;
    localparam int ROW_COUNT    = 25;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [SLOT_W-1:0] slot;
        logic [VAL_W-1:0]  value;
        logic              last;
    } t_slot_result;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [VAL_W-1:0]  key;
        logic [VAL_W-1:0]  new_value;
        logic [SLOT_W-1:0] slot_index;
        logic              typed;
        logic [ST_W-1:0]   status;
        logic [SLOT_W-1:0] slot;
        logic [VAL_W-1:0]  value;
    } t_directed_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    // key [31:0], new_value [63:32], slot_index [66:64], zero fill
    logic [IN_TDATA_W-1:0]  i_s_tdata;
    // opcode [2:0]
    logic [OP_W-1:0]        i_s_tuser;
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    // slot_found [2:0], slot_value [34:3], zero fill
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    // status [2:0]
    logic [ST_W-1:0]        o_m_tuser;
    logic                   o_m_tlast;

    logic [VAL_W-1:0] table_model [TABLE_DEPTH];
    t_slot_result     pending_results [$];

    int send_idle_pct;
    int recv_stall_pct;
    int hold_requests;
    int hold_served;
    int hold_left;
    int idle_cycles;
    int fail_count;
    int results_checked;
    int dumps_requested;
    int requests_by_op [8];
    int results_by_status [8];

    t_directed_row directed_rows [ROW_COUNT] = '{
        '{OP_LOOKUP, 32'h0,        32'h0,        3'd0, 1'b0, ST_OK,       3'd0, 32'h0},
        '{OP_INSERT, 32'h0,        32'h0,        3'd0, 1'b1, ST_DUP,      3'd0, 32'h0},
        '{OP_LOOKUP, 32'h5,        32'h0,        3'd0, 1'b1, ST_NOTFOUND, 3'd0, 32'h0},
        '{OP_RMPOS,  32'h0,        32'h0,        3'd4, 1'b1, ST_BADPOS,   3'd0, 32'h0},
        '{OP_RMPOS,  32'h0,        32'h0,        3'd7, 1'b1, ST_BADPOS,   3'd0, 32'h0},
        '{OP_RMVAL,  32'h9,        32'h0,        3'd0, 1'b1, ST_NOTFOUND, 3'd0, 32'h0},
        '{OP_REPL,   32'h9,        32'h1,        3'd0, 1'b1, ST_NOTFOUND, 3'd0, 32'h0},
        '{OP_INSERT, 32'h7FFFFFFF, 32'h0,        3'd0, 1'b1, ST_OK,       3'd0, 32'h7FFFFFFF},
        '{OP_INSERT, 32'h80000000, 32'h0,        3'd0, 1'b1, ST_OK,       3'd1, 32'h80000000},
        '{OP_INSERT, 32'hFFFFFFFF, 32'h0,        3'd0, 1'b1, ST_OK,       3'd2, 32'hFFFFFFFF},
        '{OP_INSERT, 32'hFFFFFFFF, 32'h0,        3'd0, 1'b1, ST_DUP,      3'd0, 32'h0},
        '{OP_INSERT, 32'h1,        32'h0,        3'd0, 1'b1, ST_OK,       3'd3, 32'h1},
        '{OP_INSERT, 32'h2,        32'h0,        3'd0, 1'b1, ST_FULL,     3'd0, 32'h0},
        '{OP_INSERT, 32'h0,        32'h0,        3'd0, 1'b1, ST_FULL,     3'd0, 32'h0},
        '{OP_RMVAL,  32'h0,        32'h0,        3'd0, 1'b1, ST_NOTFOUND, 3'd0, 32'h0},
        '{OP_LOOKUP, 32'h0,        32'h0,        3'd0, 1'b0, ST_OK,       3'd0, 32'h0},
        '{OP_LOOKUP, 32'h80000000, 32'h0,        3'd0, 1'b0, ST_OK,       3'd0, 32'h0},
        '{OP_REPL,   32'h1,        32'hAAAAAAAA, 3'd0, 1'b0, ST_OK,       3'd0, 32'h0},
        '{OP_RMPOS,  32'h0,        32'h0,        3'd3, 1'b0, ST_OK,       3'd0, 32'h0},
        '{OP_REPL,   32'h0,        32'h55555555, 3'd0, 1'b0, ST_OK,       3'd0, 32'h0},
        '{OP_RMVAL,  32'h7FFFFFFF, 32'h0,        3'd0, 1'b0, ST_OK,       3'd0, 32'h0},
        '{OP_RMVAL,  32'h0,        32'h0,        3'd0, 1'b0, ST_OK,       3'd0, 32'h0},
        '{3'd5,      32'h5,        32'h5,        3'd5, 1'b0, ST_OK,       3'd0, 32'h0},
        '{3'd7,      32'hFFFFFFFF, 32'hFFFFFFFF, 3'd7, 1'b0, ST_OK,       3'd0, 32'h0},
        '{OP_LOOKUP, 32'h0,        32'h0,        3'd0, 1'b0, ST_OK,       3'd0, 32'h0}
    };

    unique_value_slot_table #(
        .DEPTH(TABLE_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int find_slot(input logic [VAL_W-1:0] v);
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (table_model[i] == v) begin
                return i;
            end
        end
        return TABLE_DEPTH;
    endfunction

    function automatic void expect_slot(input int pos, input logic [VAL_W-1:0] v,
                                        input logic last);
        t_slot_result r;
        r.status = ST_OK;
        r.slot   = SLOT_W'(pos);
        r.value  = v;
        r.last   = last;
        pending_results.push_back(r);
    endfunction

    function automatic void expect_status(input logic [ST_W-1:0] st);
        t_slot_result r;
        r.status = st;
        r.slot   = '0;
        r.value  = '0;
        r.last   = 1'b1;
        pending_results.push_back(r);
    endfunction

    function automatic void predict_request(input logic [OP_W-1:0] op,
                                            input logic [VAL_W-1:0] key,
                                            input logic [VAL_W-1:0] new_value,
                                            input logic [SLOT_W-1:0] slot_index);
        int pos;
        requests_by_op[op]++;
        case (op)
            OP_INSERT: begin
                if (find_slot(key) < TABLE_DEPTH) begin
                    expect_status(ST_DUP);
                end else begin
                    pos = find_slot('0);
                    if (pos >= TABLE_DEPTH) begin
                        expect_status(ST_FULL);
                    end else begin
                        table_model[pos] = key;
                        expect_slot(pos, key, 1'b1);
                    end
                end
            end
            OP_RMVAL: begin
                pos = find_slot(key);
                if (pos >= TABLE_DEPTH) begin
                    expect_status(ST_NOTFOUND);
                end else begin
                    table_model[pos] = '0;
                    expect_slot(pos, '0, 1'b1);
                end
            end
            OP_RMPOS: begin
                if (int'(slot_index) >= TABLE_DEPTH) begin
                    expect_status(ST_BADPOS);
                end else begin
                    table_model[slot_index] = '0;
                    expect_slot(int'(slot_index), '0, 1'b1);
                end
            end
            OP_REPL: begin
                pos = find_slot(key);
                if (pos >= TABLE_DEPTH) begin
                    expect_status(ST_NOTFOUND);
                end else begin
                    table_model[pos] = new_value;
                    expect_slot(pos, new_value, 1'b1);
                end
            end
            OP_LOOKUP: begin
                if (key == '0) begin
                    dumps_requested++;
                    for (int i = 0; i < TABLE_DEPTH; i++) begin
                        expect_slot(i, table_model[i], i == TABLE_DEPTH - 1);
                    end
                end else begin
                    pos = find_slot(key);
                    if (pos >= TABLE_DEPTH) begin
                        expect_status(ST_NOTFOUND);
                    end else begin
                        expect_slot(pos, table_model[pos], 1'b1);
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    task automatic offer_request(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] key,
                                 input logic [VAL_W-1:0] new_value,
                                 input logic [SLOT_W-1:0] slot_index);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= IN_TDATA_W'({slot_index, new_value, key});
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
        predict_request(op, key, new_value, slot_index);
    endtask

    function automatic logic [VAL_W-1:0] pick_key();
        int r;
        int v;
        r = $urandom_range(99);
        if (r < 45) begin
            return table_model[$urandom_range(TABLE_DEPTH - 1)];
        end else if (r < 55) begin
            return '0;
        end else if (r < 78) begin
            v = $urandom_range(6, 1);
            return $urandom_range(1) ? VAL_W'(-v) : VAL_W'(v);
        end else if (r < 82) begin
            return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
        end
        return $urandom;
    endfunction

    function automatic logic [OP_W-1:0] pick_op();
        int r;
        r = $urandom_range(99);
        if (r < 32) begin
            return OP_INSERT;
        end else if (r < 46) begin
            return OP_RMVAL;
        end else if (r < 58) begin
            return OP_RMPOS;
        end else if (r < 72) begin
            return OP_REPL;
        end else if (r < 95) begin
            return OP_LOOKUP;
        end
        return OP_W'($urandom_range(7, 5));
    endfunction

    always @(posedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left  = hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_slot_result seen;
        t_slot_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            seen.status = o_m_tuser;
            seen.slot   = o_m_tdata[SLOT_W-1:0];
            seen.value  = o_m_tdata[SLOT_W +: VAL_W];
            seen.last   = o_m_tlast;
            results_checked++;
            results_by_status[seen.status]++;
            if (pending_results.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected item: status %0d slot %0d value %0d last %0b",
                         $time, seen.status, seen.slot, $signed(seen.value), seen.last);
            end else begin
                want = pending_results.pop_front();
                if (seen.status !== want.status || seen.slot !== want.slot ||
                    seen.value !== want.value || seen.last !== want.last) begin
                    fail_count++;
                    $display("%0t: mismatch: expected status %0d slot %0d value %0d last %0b",
                             $time, want.status, want.slot, $signed(want.value), want.last);
                    $display("%0t:           actual status %0d slot %0d value %0d last %0b",
                             $time, seen.status, seen.slot, $signed(seen.value), seen.last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, pending_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int sent;
        logic [OP_W-1:0]  op;
        logic [VAL_W-1:0] new_value;
        logic [SLOT_W-1:0] slot_index;
        t_slot_result typed_result;

        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= '0;
        i_m_tready <= 1'b0;
        send_idle_pct   = 31;
        recv_stall_pct  = 69;
        hold_requests   = 0;
        hold_served     = 0;
        hold_left       = 0;
        idle_cycles     = 0;
        fail_count      = 0;
        results_checked = 0;
        dumps_requested = 0;
        for (int i = 0; i < 8; i++) begin
            requests_by_op[i]    = 0;
            results_by_status[i] = 0;
        end
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            table_model[i] = '0;
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int row = 0; row < ROW_COUNT; row++) begin
            offer_request(directed_rows[row].op, directed_rows[row].key,
                          directed_rows[row].new_value, directed_rows[row].slot_index);
            if (directed_rows[row].typed) begin
                void'(pending_results.pop_back());
                typed_result.status = directed_rows[row].status;
                typed_result.slot   = directed_rows[row].slot;
                typed_result.value  = directed_rows[row].value;
                typed_result.last   = 1'b1;
                pending_results.push_back(typed_result);
            end
        end

        for (int phase = 0; phase < 3; phase++) begin
            i_s_tvalid <= 1'b0;
            do begin
                @(posedge i_clk);
            end while (pending_results.size() != 0);
            send_idle_pct  = (phase == 0) ? 31 : (phase == 1) ? 69 : 0;
            recv_stall_pct = (phase == 0) ? 69 : (phase == 1) ? 31 : 0;
            if (phase == 2) begin
                hold_requests++;
            end
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                op         = pick_op();
                new_value  = ($urandom_range(9) == 0) ? '0 :
                             ($urandom_range(1) ? pick_key() : VAL_W'($urandom));
                slot_index = ($urandom_range(99) < 80) ?
                             SLOT_W'($urandom_range(TABLE_DEPTH - 1)) :
                             SLOT_W'($urandom_range(7));
                offer_request(op, pick_key(), new_value, slot_index);
                if (op <= OP_LOOKUP) begin
                    sent++;
                end
            end
        end
        i_s_tvalid <= 1'b0;

        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Requests: %0d insert, %0d remove by value, %0d remove by position, %0d replace,",
                 requests_by_op[OP_INSERT], requests_by_op[OP_RMVAL], requests_by_op[OP_RMPOS],
                 requests_by_op[OP_REPL]);
        $display("%0d lookup (%0d dumps); %0d items checked, %0d full, %0d dup, %0d bad position",
                 requests_by_op[OP_LOOKUP], dumps_requested, results_checked,
                 results_by_status[ST_FULL], results_by_status[ST_DUP],
                 results_by_status[ST_BADPOS]);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
